@@ hw/rtl/atmb_pkg.sv @@
`default_nettype none

package atmb_pkg;

    localparam int MAX_ATLAS = 256;
    localparam int GRID      = 4;
    localparam int MIP_DEPTH = 32768;
    localparam int ATLAS_AW  = $clog2(MAX_ATLAS * MAX_ATLAS);
    localparam int MIP_AW    = $clog2(MIP_DEPTH);
    localparam int LAYERS    = GRID * GRID;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_BUILD = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_NOP   = 2'd3;

    localparam logic [2:0] CFG_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_BYTES  = 3'd2;
    localparam logic [2:0] CFG_EXPAND = 3'd3;
    localparam logic [2:0] CFG_WORD   = 3'd4;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    typedef logic [3:0] status_t;

    localparam status_t STS_OK                 = 4'd0;
    localparam status_t STS_ZERO_SIZE          = 4'd1;
    localparam status_t STS_NOT_SQUARE         = 4'd2;
    localparam status_t STS_NOT_DIVISIBLE      = 4'd3;
    localparam status_t STS_BAD_BYTES          = 4'd4;
    localparam status_t STS_WORD_NEEDS_TWO     = 4'd5;
    localparam status_t STS_EXPAND_NEEDS_THREE = 4'd6;
    localparam status_t STS_MODES_EXCLUSIVE    = 4'd7;
    localparam status_t STS_NOT_BUILT          = 4'd8;
    localparam status_t STS_OUT_OF_RANGE       = 4'd9;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  atlas_x;
        logic [7:0]  atlas_y;
        logic [31:0] pixel_value;
        logic [3:0]  layer_index;
        logic [2:0]  mip_level;
        logic [5:0]  texel_x;
        logic [5:0]  texel_y;
    } req_t;

    typedef struct packed {
        logic [31:0] texel_value;
        status_t     status;
        logic [2:0]  level_count;
        logic [6:0]  tile_size;
    } rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/atlas_tile_mip_builder_top.sv @@
// Tiled atlas store with per-tile box-filter mip chains.
// Channels: req (valid/ready, req_t), rsp (valid/ready, rsp_t), and a cfg write
// channel (cfg_index, cfg_data) that is always ready; the user must use it only
// while idle, which the block does not enforce. A pixel write gives no response.
// A read request is captured in the pending stage while the atlas or mip memory
// registers its read data; the response then moves to the output register.
// Reads can be accepted every cycle while responses drain and no build runs.
// A build with a bad configuration answers via the pending stage. A good
// build walks every texel of mip levels 1 and up: for each texel, four reads
// through the single read port of a memory, then one write. Requests wait
// meanwhile.
// Reset clears configuration to its defaults and drops any built chain; the
// memories keep their contents and are not cleared.
// When the receiver stalls, one response sits in the output register and one
// more in a pending stage; further requests then wait.
`default_nettype none

module atlas_tile_mip_builder_top
    import atmb_pkg::*;
#(
    parameter int ATLAS_WORDS = MAX_ATLAS * MAX_ATLAS,
    parameter int MIP_WORDS   = MIP_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire req_t       req,
    output logic            rsp_valid,
    input  wire logic       rsp_ready,
    output rsp_t            rsp,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [8:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_BUILD = 2'b10
    } state_t;

    localparam logic [2:0] PH_LAST = 3'd4;

    function automatic logic [31:0] fmt_pixel(logic [31:0] v, logic [2:0] nb, logic ex);
        logic [31:0] r;
        case (nb)
            3'd1:    r = {24'd0, v[7:0]};
            3'd2:    r = {16'd0, v[15:0]};
            3'd3:    r = {8'd0, v[23:0]};
            default: r = v;
        endcase
        if (ex)
        begin
            r = {8'hFF, r[23:0]};
        end
        return r;
    endfunction

    state_t state_reg, state_next;

    logic [8:0] width_reg, height_reg;
    logic [2:0] bytes_reg;
    logic       expand_reg, word_reg;

    logic        built_reg;
    logic [2:0]  levels_reg;
    logic [6:0]  tile_reg;
    logic [2:0]  lbytes_reg;
    logic        lexp_reg, lword_reg;
    logic [MIP_AW-1:0] lw_reg;
    logic [MIP_AW-1:0] off_reg [8];

    logic [3:0]  b_layer_reg;
    logic [2:0]  b_lvl_reg;
    logic [5:0]  b_x_reg, b_y_reg;
    logic [2:0]  b_ph_reg;
    logic [MIP_AW-1:0] dst_reg, lvl_start_reg, src_base_reg;
    logic [9:0]  acc_reg [4];
    logic [17:0] accw_reg;

    logic        p_valid_reg, p_texel_reg, p_atlas_reg;
    status_t     p_status_reg;
    logic [2:0]  p_levels_reg;
    logic [6:0]  p_tile_reg;

    logic        rsp_valid_reg;
    rsp_t        rsp_reg;

    logic [31:0] atlas_dout, mip_dout;

    // request decode
    logic    adv, idle, acc_req, is_write, is_build, is_read;
    status_t chk;
    logic [6:0] new_t;
    logic [2:0] new_cnt;

    assign cfg_ready = 1'b1;
    assign adv       = !rsp_valid_reg || rsp_ready;
    assign idle      = (state_reg == ST_IDLE);
    assign req_ready = idle && (!p_valid_reg || adv);
    assign acc_req   = req_valid && req_ready;
    assign is_write  = (req.req_type == REQ_WRITE);
    assign is_build  = (req.req_type == REQ_BUILD);
    assign is_read   = (req.req_type == REQ_READ);

    always_comb
    begin
        chk = STS_OK;
        if (width_reg == 9'd0 || height_reg == 9'd0)
        begin
            chk = STS_ZERO_SIZE;
        end
        else if (width_reg != height_reg)
        begin
            chk = STS_NOT_SQUARE;
        end
        else if (width_reg[1:0] != 2'd0)
        begin
            chk = STS_NOT_DIVISIBLE;
        end
        else if (bytes_reg < 3'd1 || bytes_reg > 3'd4)
        begin
            chk = STS_BAD_BYTES;
        end
        else if (word_reg && bytes_reg != 3'd2)
        begin
            chk = STS_WORD_NEEDS_TWO;
        end
        else if (expand_reg && bytes_reg != 3'd3)
        begin
            chk = STS_EXPAND_NEEDS_THREE;
        end
        else if (expand_reg && word_reg)
        begin
            chk = STS_MODES_EXCLUSIVE;
        end
        else if (width_reg > 9'(MAX_ATLAS))
        begin
            chk = STS_OUT_OF_RANGE;
        end
    end

    assign new_t = width_reg[8:2];

    always_comb
    begin
        new_cnt = 3'd0;
        for (int i = 0; i < 7; i++)
        begin
            if (new_t[i])
            begin
                new_cnt = 3'(i + 1);
            end
        end
    end

    // read addressing
    logic [6:0] rd_d;
    logic       rd_bad;
    logic [8:0] rd_ax, rd_ay;
    logic [MIP_AW-1:0] rd_mip_addr, rd_layer_base;

    assign rd_d   = tile_reg >> req.mip_level;
    assign rd_bad = (req.mip_level >= levels_reg) || ({1'b0, req.texel_x} >= rd_d)
                    || ({1'b0, req.texel_y} >= rd_d);
    assign rd_ax  = 9'(req.layer_index[1:0]) * 9'(tile_reg) + 9'(req.texel_x);
    assign rd_ay  = 9'(req.layer_index[3:2]) * 9'(tile_reg) + 9'(req.texel_y);
    assign rd_layer_base = MIP_AW'(req.layer_index) * lw_reg;
    assign rd_mip_addr = rd_layer_base + off_reg[req.mip_level]
                         + MIP_AW'(req.texel_y) * MIP_AW'(rd_d) + MIP_AW'(req.texel_x);

    // build addressing
    logic [6:0] b_d, b_ds, b_sx, b_sy;
    logic [8:0] b_ax, b_ay;
    logic [MIP_AW-1:0] b_src_addr;
    logic       b_issue, b_write, last_x, last_y, last_lvl, last_layer;
    logic [31:0] b_src;
    logic [9:0]  lane_sum [4];
    logic [17:0] word_sum;
    logic [31:0] b_avg;

    assign b_d   = tile_reg >> b_lvl_reg;
    assign b_ds  = tile_reg >> (b_lvl_reg - 3'd1);
    assign b_sx  = {b_x_reg, b_ph_reg[0]};
    assign b_sy  = {b_y_reg, b_ph_reg[1]};
    assign b_ax  = 9'(b_layer_reg[1:0]) * 9'(tile_reg) + 9'(b_sx);
    assign b_ay  = 9'(b_layer_reg[3:2]) * 9'(tile_reg) + 9'(b_sy);
    assign b_src_addr = src_base_reg + MIP_AW'(b_sy) * MIP_AW'(b_ds) + MIP_AW'(b_sx);
    assign b_issue = (state_reg == ST_BUILD) && (b_ph_reg != PH_LAST);
    assign b_write = (state_reg == ST_BUILD) && (b_ph_reg == PH_LAST);
    assign last_x  = (7'(b_x_reg) == b_d - 7'd1);
    assign last_y  = (7'(b_y_reg) == b_d - 7'd1);
    assign last_lvl   = (b_lvl_reg == levels_reg - 3'd1);
    assign last_layer = (b_layer_reg == 4'(LAYERS - 1));

    assign b_src = (b_lvl_reg == 3'd1) ? fmt_pixel(atlas_dout, lbytes_reg, lexp_reg) : mip_dout;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            lane_sum[i] = acc_reg[i] + 10'(b_src[8*i +: 8]);
        end
        word_sum = accw_reg + 18'(b_src[15:0]);
        if (lword_reg)
        begin
            b_avg = {16'd0, word_sum[17:2]};
        end
        else
        begin
            b_avg = {lane_sum[3][9:2], lane_sum[2][9:2], lane_sum[1][9:2], lane_sum[0][9:2]};
        end
    end

    // memories
    logic atlas_re, mip_re, mip_we;
    logic [ATLAS_AW-1:0] atlas_raddr;
    logic [MIP_AW-1:0]   mip_raddr;

    assign atlas_re    = (acc_req && is_read) || b_issue;
    assign mip_re      = (acc_req && is_read) || b_issue;
    assign atlas_raddr = b_issue ? ATLAS_AW'({b_ay[7:0], b_ax[7:0]})
                                 : ATLAS_AW'({rd_ay[7:0], rd_ax[7:0]});
    assign mip_raddr   = b_issue ? b_src_addr : rd_mip_addr;
    assign mip_we      = b_write;

    atmb_ram #(
        .WIDTH (32),
        .DEPTH (ATLAS_WORDS)
    ) u_atlas_ram (
        .clk   (clk),
        .we    (acc_req && is_write),
        .waddr (ATLAS_AW'({req.atlas_y, req.atlas_x})),
        .wdata (req.pixel_value),
        .re    (atlas_re),
        .raddr (atlas_raddr),
        .rdata (atlas_dout)
    );

    atmb_ram #(
        .WIDTH (32),
        .DEPTH (MIP_WORDS)
    ) u_mip_ram (
        .clk   (clk),
        .we    (mip_we),
        .waddr (dst_reg),
        .wdata (b_avg),
        .re    (mip_re),
        .raddr (mip_raddr),
        .rdata (mip_dout)
    );

    // control
    logic start_ok, start_bad, build_done;

    assign start_ok   = acc_req && is_build && (chk == STS_OK);
    assign start_bad  = acc_req && is_build && (chk != STS_OK);
    assign build_done = b_write && last_x && last_y && last_lvl && last_layer;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_ok && new_cnt != 3'd1)
                begin
                    state_next = ST_BUILD;
                end
            end
            ST_BUILD:
            begin
                if (build_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= 9'd256;
            height_reg    <= 9'd256;
            bytes_reg     <= 3'd4;
            expand_reg    <= 1'b0;
            word_reg      <= 1'b0;
            built_reg     <= 1'b0;
            levels_reg    <= 3'd0;
            tile_reg      <= 7'd0;
            lbytes_reg    <= 3'd0;
            lexp_reg      <= 1'b0;
            lword_reg     <= 1'b0;
            p_valid_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_WIDTH:  width_reg  <= cfg_data;
                    CFG_HEIGHT: height_reg <= cfg_data;
                    CFG_BYTES:  bytes_reg  <= cfg_data[2:0];
                    CFG_EXPAND: expand_reg <= cfg_data[0];
                    CFG_WORD:   word_reg   <= cfg_data[0];
                    default:    ;
                endcase
            end
            if (acc_req && is_write)
            begin
                built_reg  <= 1'b0;
                levels_reg <= 3'd0;
                tile_reg   <= 7'd0;
            end
            if (start_bad)
            begin
                built_reg  <= 1'b0;
                levels_reg <= 3'd0;
                tile_reg   <= 7'd0;
            end
            if (start_ok)
            begin
                built_reg  <= (new_cnt == 3'd1);
                levels_reg <= new_cnt;
                tile_reg   <= new_t;
                lbytes_reg <= bytes_reg;
                lexp_reg   <= expand_reg;
                lword_reg  <= word_reg;
            end
            if (build_done)
            begin
                built_reg <= 1'b1;
            end

            if ((acc_req && (is_read || start_bad || (start_ok && new_cnt == 3'd1)))
                || build_done)
            begin
                p_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                p_valid_reg <= 1'b0;
            end

            if (adv)
            begin
                rsp_valid_reg <= p_valid_reg;
            end
        end
    end

    // pending stage, response register and build datapath
    always_ff @(posedge clk)
    begin
        if (acc_req && is_read)
        begin
            p_texel_reg  <= built_reg && !rd_bad;
            p_atlas_reg  <= (req.mip_level == 3'd0);
            p_status_reg <= !built_reg ? STS_NOT_BUILT : (rd_bad ? STS_OUT_OF_RANGE : STS_OK);
            p_levels_reg <= built_reg ? levels_reg : 3'd0;
            p_tile_reg   <= built_reg ? tile_reg : 7'd0;
        end
        else if (start_bad)
        begin
            p_texel_reg  <= 1'b0;
            p_status_reg <= chk;
            p_levels_reg <= 3'd0;
            p_tile_reg   <= 7'd0;
        end
        else if (start_ok)
        begin
            p_texel_reg  <= 1'b0;
            p_status_reg <= STS_OK;
            p_levels_reg <= new_cnt;
            p_tile_reg   <= new_t;
        end

        if (adv && p_valid_reg)
        begin
            rsp_reg.texel_value <= !p_texel_reg ? 32'd0
                                 : (p_atlas_reg ? fmt_pixel(atlas_dout, lbytes_reg, lexp_reg)
                                                : mip_dout);
            rsp_reg.status      <= p_status_reg;
            rsp_reg.level_count <= p_levels_reg;
            rsp_reg.tile_size   <= p_tile_reg;
        end

        if (state_reg == ST_BUILD)
        begin
            if (b_ph_reg == 3'd0)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    acc_reg[i] <= 10'd0;
                end
                accw_reg <= 18'd0;
            end
            else
            begin
                acc_reg  <= lane_sum;
                accw_reg <= word_sum;
            end

            if (b_ph_reg != PH_LAST)
            begin
                b_ph_reg <= b_ph_reg + 3'd1;
            end
            else
            begin
                b_ph_reg <= 3'd0;
                dst_reg  <= dst_reg + 1'b1;
                if (!last_x)
                begin
                    b_x_reg <= b_x_reg + 6'd1;
                end
                else
                begin
                    b_x_reg <= 6'd0;
                    if (!last_y)
                    begin
                        b_y_reg <= b_y_reg + 6'd1;
                    end
                    else
                    begin
                        b_y_reg <= 6'd0;
                        lvl_start_reg <= dst_reg + 1'b1;
                        if (!last_lvl)
                        begin
                            b_lvl_reg    <= b_lvl_reg + 3'd1;
                            src_base_reg <= lvl_start_reg;
                            if (b_layer_reg == 4'd0)
                            begin
                                off_reg[b_lvl_reg + 3'd1] <= dst_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            b_lvl_reg <= 3'd1;
                            if (b_layer_reg == 4'd0)
                            begin
                                lw_reg <= dst_reg + 1'b1;
                            end
                            if (!last_layer)
                            begin
                                b_layer_reg <= b_layer_reg + 4'd1;
                            end
                        end
                    end
                end
            end
        end
        else if (start_ok)
        begin
            b_layer_reg   <= 4'd0;
            b_lvl_reg     <= 3'd1;
            b_x_reg       <= 6'd0;
            b_y_reg       <= 6'd0;
            b_ph_reg      <= 3'd0;
            dst_reg       <= '0;
            lvl_start_reg <= '0;
            src_base_reg  <= '0;
            lw_reg        <= '0;
            off_reg[0]    <= '0;
            off_reg[1]    <= '0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

@@ hw/rtl/atmb_ram.sv @@
`default_nettype none

module atmb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import atmb_pkg::*;

    localparam int  LIMIT_CYCLES = 4000000;
    localparam int  SETTLE       = 12;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_ready;
    req_t       req;
    logic       rsp_valid;
    logic       rsp_ready;
    rsp_t       rsp;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [8:0] cfg_data;

    atlas_tile_mip_builder_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // mirror of the block
    logic [31:0] atlas_mem [0:MAX_ATLAS*MAX_ATLAS-1];
    logic [31:0] mip_mem [0:MIP_DEPTH-1];
    bit          chain_built;
    int          chain_levels;
    int          chain_tile;
    int          chain_bytes;
    bit          chain_expand;
    bit          chain_word;
    int          reg_width;
    int          reg_height;
    int          reg_bytes;
    bit          reg_expand;
    bit          reg_word;

    req_t        pending_reqs[$];
    rsp_t        expected_rsps[$];
    bit          hold_requests;
    int          error_count;
    int          cycle_count;

    // generator bookkeeping
    bit          pixel_written [0:MAX_ATLAS*MAX_ATLAS-1];
    int          request_count;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    function automatic logic [31:0] lane_mask(input int nbytes);
        if (nbytes >= 4)
        begin
            return 32'hFFFF_FFFF;
        end
        return (32'd1 << (8 * nbytes)) - 32'd1;
    endfunction

    function automatic int level_base(input int t, input int lvl);
        int off;
        off = 0;
        for (int k = 1; k < lvl; k++)
        begin
            off += (t >> k) * (t >> k);
        end
        return off;
    endfunction

    function automatic logic [31:0] texel_at(input int layer, input int lvl, input int x,
                                             input int y);
        int          ax;
        int          ay;
        int          idx;
        logic [31:0] v;
        if (lvl == 0)
        begin
            ax = (layer % GRID) * chain_tile + x;
            ay = (layer / GRID) * chain_tile + y;
            if (ax >= MAX_ATLAS || ay >= MAX_ATLAS)
            begin
                return 32'd0;
            end
            v = atlas_mem[ay * MAX_ATLAS + ax] & lane_mask(chain_bytes);
            if (chain_expand)
            begin
                v = {8'hFF, v[23:0]};
            end
            return v;
        end
        idx = layer * level_base(chain_tile, chain_levels) + level_base(chain_tile, lvl)
              + y * (chain_tile >> lvl) + x;
        if (idx >= MIP_DEPTH)
        begin
            return 32'd0;
        end
        return mip_mem[idx];
    endfunction

    function automatic logic [31:0] box_average(input logic [31:0] a, input logic [31:0] b,
                                                input logic [31:0] c, input logic [31:0] d);
        logic [31:0] r;
        logic [17:0] s;
        r = '0;
        if (chain_word)
        begin
            s = a[15:0] + b[15:0] + c[15:0] + d[15:0];
            return {16'd0, s[17:2]};
        end
        for (int sh = 0; sh < 32; sh += 8)
        begin
            s = a[sh +: 8] + b[sh +: 8] + c[sh +: 8] + d[sh +: 8];
            r[sh +: 8] = s[9:2];
        end
        return r;
    endfunction

    function automatic status_t config_status();
        if (reg_width == 0 || reg_height == 0) return STS_ZERO_SIZE;
        if (reg_width != reg_height) return STS_NOT_SQUARE;
        if (reg_width % GRID != 0) return STS_NOT_DIVISIBLE;
        if (reg_bytes < 1 || reg_bytes > 4) return STS_BAD_BYTES;
        if (reg_word && reg_bytes != 2) return STS_WORD_NEEDS_TWO;
        if (reg_expand && reg_bytes != 3) return STS_EXPAND_NEEDS_THREE;
        if (reg_expand && reg_word) return STS_MODES_EXCLUSIVE;
        if (reg_width > MAX_ATLAS) return STS_OUT_OF_RANGE;
        return STS_OK;
    endfunction

    function automatic int chain_length(input int t);
        int cnt;
        cnt = 1;
        for (int s = t; s > 1; s >>= 1)
        begin
            cnt++;
        end
        return cnt;
    endfunction

    function automatic status_t build_chains();
        status_t st;
        int      t;
        int      cnt;
        int      d;
        int      off;
        st = config_status();
        chain_built  = 1'b0;
        chain_levels = 0;
        chain_tile   = 0;
        if (st != STS_OK)
        begin
            return st;
        end
        t   = reg_width / GRID;
        cnt = chain_length(t);
        if (level_base(t, cnt) * LAYERS > MIP_DEPTH)
        begin
            return STS_OUT_OF_RANGE;
        end
        chain_tile   = t;
        chain_bytes  = reg_bytes;
        chain_expand = reg_expand;
        chain_word   = reg_word;
        chain_levels = cnt;
        for (int layer = 0; layer < LAYERS; layer++)
        begin
            for (int lvl = 1; lvl < cnt; lvl++)
            begin
                d   = t >> lvl;
                off = layer * level_base(t, cnt) + level_base(t, lvl);
                for (int y = 0; y < d; y++)
                begin
                    for (int x = 0; x < d; x++)
                    begin
                        mip_mem[off + y * d + x] = box_average(
                            texel_at(layer, lvl - 1, 2 * x, 2 * y),
                            texel_at(layer, lvl - 1, 2 * x + 1, 2 * y),
                            texel_at(layer, lvl - 1, 2 * x, 2 * y + 1),
                            texel_at(layer, lvl - 1, 2 * x + 1, 2 * y + 1));
                    end
                end
            end
        end
        chain_built = 1'b1;
        return STS_OK;
    endfunction

    task automatic apply_request(input req_t r);
        rsp_t e;
        e = '0;
        if (r.req_type == REQ_WRITE)
        begin
            atlas_mem[{r.atlas_y, r.atlas_x}] = r.pixel_value;
            chain_built  = 1'b0;
            chain_levels = 0;
            chain_tile   = 0;
            return;
        end
        if (r.req_type == REQ_BUILD)
        begin
            e.status = build_chains();
        end
        else if (r.req_type == REQ_READ)
        begin
            if (!chain_built)
            begin
                e.status = STS_NOT_BUILT;
            end
            else if (r.mip_level >= chain_levels || r.texel_x >= (chain_tile >> r.mip_level)
                     || r.texel_y >= (chain_tile >> r.mip_level))
            begin
                e.status = STS_OUT_OF_RANGE;
            end
            else
            begin
                e.status      = STS_OK;
                e.texel_value = texel_at(r.layer_index, r.mip_level, r.texel_x, r.texel_y);
            end
        end
        else
        begin
            return;
        end
        e.level_count = chain_built ? chain_levels[2:0] : 3'd0;
        e.tile_size   = chain_built ? chain_tile[6:0] : 7'd0;
        expected_rsps.insert(expected_rsps.size(), e);
    endtask

    // request driver
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid  <= 1'b0;
            req        <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                apply_request(req);
                void'(pending_reqs.pop_front());
            end
            if (!(req_valid && !req_ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (hold_requests || pending_reqs.size() == 0)
                begin
                    req_valid <= 1'b0;
                end
                else
                begin
                    req_valid <= 1'b1;
                    req       <= pending_reqs[0];
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                    end
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        gap_left = ($urandom % 3 == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // response monitor
    int   stall_phase;
    rsp_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready   <= 1'b0;
            stall_phase = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    report("unexpected response", rsp.texel_value, 32'd0);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.texel_value !== want.texel_value)
                        report("texel_value", rsp.texel_value, want.texel_value);
                    if (rsp.status !== want.status)
                        report("status", 32'(rsp.status), 32'(want.status));
                    if (rsp.level_count !== want.level_count)
                        report("level_count", 32'(rsp.level_count), 32'(want.level_count));
                    if (rsp.tile_size !== want.tile_size)
                        report("tile_size", 32'(rsp.tile_size), 32'(want.tile_size));
                end
            end
            stall_phase++;
            case (stall_phase[9:8])
                2'd0: rsp_ready <= 1'b1;
                2'd1: rsp_ready <= ($urandom % 4 != 0);
                2'd2: rsp_ready <= (stall_phase[4:0] < 5'd9);
                default: rsp_ready <= 1'($urandom);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send(input req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
        request_count++;
        if (r.req_type == REQ_WRITE)
        begin
            pixel_written[{r.atlas_y, r.atlas_x}] = 1'b1;
        end
    endtask

    task automatic send_write(input int x, input int y, input logic [31:0] v);
        req_t r;
        r             = '0;
        r.req_type    = REQ_WRITE;
        r.atlas_x     = x[7:0];
        r.atlas_y     = y[7:0];
        r.pixel_value = v;
        r.layer_index = 4'($urandom);
        r.texel_x     = 6'($urandom);
        send(r);
    endtask

    task automatic send_build();
        req_t r;
        r          = req_t'({$urandom, $urandom, $urandom});
        r.req_type = REQ_BUILD;
        send(r);
    endtask

    task automatic send_read(input int layer, input int lvl, input int x, input int y);
        req_t r;
        r             = '0;
        r.req_type    = REQ_READ;
        r.layer_index = layer[3:0];
        r.mip_level   = lvl[2:0];
        r.texel_x     = x[5:0];
        r.texel_y     = y[5:0];
        r.pixel_value = {$urandom};
        send(r);
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[8:0];
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WIDTH:  reg_width  = value & 9'h1FF;
            CFG_HEIGHT: reg_height = value & 9'h1FF;
            CFG_BYTES:  reg_bytes  = value & 3'h7;
            CFG_EXPAND: reg_expand = value[0];
            CFG_WORD:   reg_word   = value[0];
            default: ;
        endcase
    endtask

    task automatic set_format(input int w, input int bytes, input bit expand, input bit word);
        drain();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, w);
        write_reg(CFG_BYTES, bytes);
        write_reg(CFG_EXPAND, expand);
        write_reg(CFG_WORD, word);
    endtask

    task automatic fill_square(input int w, input bit refresh);
        for (int y = 0; y < w; y++)
        begin
            for (int x = 0; x < w; x++)
            begin
                if (!pixel_written[y * MAX_ATLAS + x] || (refresh && $urandom % 3 == 0))
                begin
                    send_write(x, y, $urandom);
                end
            end
        end
    endtask

    task automatic random_reads(input int n, input int t);
        int cnt;
        int lvl;
        cnt = chain_length(t);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom % 6 == 0)
            begin
                send_read($urandom, $urandom, $urandom, $urandom);
            end
            else
            begin
                lvl = $urandom % cnt;
                send_read($urandom % LAYERS, lvl, $urandom % (t >> lvl),
                          $urandom % (t >> lvl));
            end
        end
    endtask

    int   w;
    int   bytes;
    bit   expand;
    bit   word;
    bit   pressed;
    req_t noise;

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        hold_requests = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        request_count = 0;
        chain_built   = 1'b0;
        chain_levels  = 0;
        chain_tile    = 0;
        chain_bytes   = 0;
        chain_expand  = 1'b0;
        chain_word    = 1'b0;
        reg_width     = 256;
        reg_height    = 256;
        reg_bytes     = 4;
        reg_expand    = 1'b0;
        reg_word      = 1'b0;
        pressed       = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_read(0, 0, 0, 0);
        noise          = req_t'({$urandom, $urandom, $urandom});
        noise.req_type = REQ_NOP;
        send(noise);
        send_write(255, 255, 32'hFFFF_FFFF);
        send_write(0, 0, 32'h0000_0000);

        set_format(0, 4, 0, 0);
        send_build();
        drain();
        write_reg(CFG_WIDTH, 8);
        write_reg(CFG_HEIGHT, 4);
        send_build();
        set_format(6, 4, 0, 0);
        send_build();
        set_format(8, 0, 0, 0);
        send_build();
        set_format(8, 7, 0, 0);
        send_build();
        set_format(8, 4, 0, 1);
        send_build();
        set_format(8, 4, 1, 0);
        send_build();
        set_format(508, 4, 0, 0);
        send_build();
        drain();
        write_reg(CFG_UNUSED, 9'h1FF);

        set_format(4, 4, 0, 0);
        fill_square(4, 1);
        send_build();
        send_read(15, 0, 0, 0);
        send_read(15, 1, 0, 0);
        send_read(0, 0, 1, 0);
        send_write(1, 1, 32'hA5A5_5A5A);
        send_read(0, 0, 0, 0);

        set_format(16, 4, 0, 0);
        fill_square(16, 0);
        send_build();
        send_read(0, 2, 0, 0);
        send_read(15, 0, 3, 3);
        send_read(5, 1, 1, 1);
        send_read(5, 7, 0, 0);
        send_read(3, 0, 0, 3);

        while (request_count < 850)
        begin
            case ($urandom % 20)
                0, 1, 2, 3, 4, 5, 6, 7: w = 4;
                8, 9, 10, 11, 12, 13: w = 8;
                19: w = 12;
                default: w = 16;
            endcase
            bytes  = $urandom_range(1, 4);
            expand = (bytes == 3) && ($urandom % 2);
            word   = (bytes == 2) && ($urandom % 2);
            if ($urandom % 10 == 0)
            begin
                bytes  = $urandom % 8;
                expand = 1'($urandom);
                word   = 1'($urandom);
            end
            set_format(w, bytes, expand, word);
            fill_square(w, 1);
            for (int i = 0; i < 3; i++)
            begin
                send_write($urandom % MAX_ATLAS, $urandom % MAX_ATLAS, $urandom);
            end
            if (!pressed && request_count > 300)
            begin
                pressed       = 1'b1;
                hold_requests = 1'b1;
                while (expected_rsps.size() != 0) @(posedge clk);
                hold_requests = 1'b0;
            end
            send_build();
            random_reads($urandom_range(15, 40), w / GRID);
            if ($urandom % 4 == 0)
            begin
                send_write($urandom % w, $urandom % w, $urandom);
                random_reads(3, w / GRID);
                send_build();
                random_reads(8, w / GRID);
            end
            if ($urandom % 5 == 0)
            begin
                noise          = req_t'({$urandom, $urandom, $urandom});
                noise.req_type = REQ_NOP;
                send(noise);
            end
            if ($urandom % 3 == 0)
            begin
                drain();
                write_reg(CFG_BYTES, $urandom_range(1, 4));
                write_reg(CFG_WORD, $urandom % 2);
                random_reads(10, w / GRID);
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (error_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/atmb_pkg.sv
hw/rtl/atmb_ram.sv
hw/rtl/atlas_tile_mip_builder_top.sv
test/tb.sv
